@@ design/qvr_pkg.sv @@
package qvr_pkg;

    localparam int COORD_BITS     = 24;
    localparam int QUAT_BITS      = 16;
    localparam int FRAC_BITS      = 2 * (QUAT_BITS - 2);
    localparam int QPROD_BITS     = 2 * QUAT_BITS;
    localparam int COEF_BITS      = QPROD_BITS + 2;
    localparam int TERM_BITS      = COEF_BITS + COORD_BITS;
    localparam int ACC_BITS       = TERM_BITS + 2;
    localparam int SHIFT_BITS     = ACC_BITS - FRAC_BITS;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic signed [QUAT_BITS-1:0] QUAT_ONE =
        QUAT_BITS'(1) <<< (QUAT_BITS - 2);
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_QUAT_X = 3'd0,
        CFG_QUAT_Y = 3'd1,
        CFG_QUAT_Z = 3'd2,
        CFG_QUAT_W = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rotated_x;
        logic signed [COORD_BITS-1:0] rotated_y;
        logic signed [COORD_BITS-1:0] rotated_z;
        logic                         clipped;
    } result_t;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t [2:0] coef_row_t;

    // per-stage load enables for the row datapath
    typedef struct packed {
        logic mul;
        logic sum;
    } adv_t;

endpackage

@@ design/qvr_row.sv @@
module qvr_row (
    input  logic                                  clk,
    input  qvr_pkg::adv_t                         adv,
    input  qvr_pkg::coef_row_t                    coef,
    input  qvr_pkg::point_t                       point,
    output logic signed [qvr_pkg::ACC_BITS-1:0]   acc
);

    logic signed [qvr_pkg::TERM_BITS-1:0] term_reg [3];
    logic signed [qvr_pkg::TERM_BITS-1:0] term_next [3];
    logic signed [qvr_pkg::ACC_BITS-1:0]  acc_reg;
    logic signed [qvr_pkg::ACC_BITS-1:0]  acc_next;

    always_comb
    begin
        term_next[0] = $signed(coef[0]) * $signed(point.point_x);
        term_next[1] = $signed(coef[1]) * $signed(point.point_y);
        term_next[2] = $signed(coef[2]) * $signed(point.point_z);
        acc_next = qvr_pkg::ACC_BITS'(term_reg[0]) + qvr_pkg::ACC_BITS'(term_reg[1])
                 + qvr_pkg::ACC_BITS'(term_reg[2]) + qvr_pkg::ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            term_reg <= term_next;
        end
        if (adv.sum)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

@@ design/quaternion_vector_rotate.sv @@
// Rotates a stream of 3-D points by a quaternion held in configuration.
//
// Configuration: cfg_write_en/cfg_index/cfg_data write quat_x, quat_y, quat_z,
// quat_w (signed Q1.14). Indexes past quat_w are ignored. Write only while no
// items are in flight.
// Input channel: point_valid/point_stall with payload point. An item is taken
// at a clock edge with point_valid high and point_stall low.
// Output channel: result_valid/result_stall with payload result (rotated,
// rounded point plus a clipped flag set when any coordinate saturated).
// Throughput: one item per cycle while result_stall is low, through five
// register stages (quaternion products, rotation matrix, matrix-by-point
// multiplies, row sums, round and saturate).
// Reset: the quaternion returns to identity and the pipeline empties.
// Stall: each stage holds only while full and blocked downstream, so empty
// stages keep filling; point_stall rises once all five stages hold items and
// result_stall is high.
module quaternion_vector_rotate (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [qvr_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [qvr_pkg::QUAT_BITS-1:0]           cfg_data,
    input  logic                                    point_valid,
    output logic                                    point_stall,
    input  qvr_pkg::point_t                         point,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output qvr_pkg::result_t                        result
);

    localparam int QB = qvr_pkg::QUAT_BITS;
    localparam int PB = qvr_pkg::QPROD_BITS;
    localparam int CB = qvr_pkg::COEF_BITS;
    localparam int SB = qvr_pkg::SHIFT_BITS;

    logic signed [QB-1:0] quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;

    logic [4:0] vld_reg;
    logic [4:0] vld_next;
    logic [4:0] adv;

    // stage 1: quaternion products
    logic signed [PB-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PB-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    qvr_pkg::point_t      pt1_reg;

    // stage 2: rotation matrix
    qvr_pkg::coef_row_t   coef_reg [3];
    qvr_pkg::coef_row_t   coef_next [3];
    qvr_pkg::point_t      pt2_reg;

    logic signed [qvr_pkg::ACC_BITS-1:0] row_acc [3];
    qvr_pkg::adv_t        row_adv;

    qvr_pkg::result_t     result_reg;
    qvr_pkg::result_t     result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
            quat_w_reg <= qvr_pkg::QUAT_ONE;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                qvr_pkg::CFG_QUAT_X: quat_x_reg <= $signed(cfg_data);
                qvr_pkg::CFG_QUAT_Y: quat_y_reg <= $signed(cfg_data);
                qvr_pkg::CFG_QUAT_Z: quat_z_reg <= $signed(cfg_data);
                qvr_pkg::CFG_QUAT_W: quat_w_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // stage k loads when it is empty or its content moves on
    always_comb
    begin
        adv[4] = !vld_reg[4] || !result_stall;
        for (int k = 3; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = point_valid;
        for (int k = 1; k < 5; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    assign point_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < 5; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            xx_reg  <= quat_x_reg * quat_x_reg;
            yy_reg  <= quat_y_reg * quat_y_reg;
            zz_reg  <= quat_z_reg * quat_z_reg;
            ww_reg  <= quat_w_reg * quat_w_reg;
            xy_reg  <= quat_x_reg * quat_y_reg;
            wz_reg  <= quat_w_reg * quat_z_reg;
            xz_reg  <= quat_x_reg * quat_z_reg;
            wy_reg  <= quat_w_reg * quat_y_reg;
            yz_reg  <= quat_y_reg * quat_z_reg;
            wx_reg  <= quat_w_reg * quat_x_reg;
            pt1_reg <= point;
        end
        if (adv[1])
        begin
            coef_reg <= coef_next;
            pt2_reg  <= pt1_reg;
        end
        if (adv[4])
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        logic signed [CB-1:0] exx, eyy, ezz, eww;
        logic signed [CB-1:0] exy, ewz, exz, ewy, eyz, ewx;
        exx = CB'(xx_reg);
        eyy = CB'(yy_reg);
        ezz = CB'(zz_reg);
        eww = CB'(ww_reg);
        exy = CB'(xy_reg);
        ewz = CB'(wz_reg);
        exz = CB'(xz_reg);
        ewy = CB'(wy_reg);
        eyz = CB'(yz_reg);
        ewx = CB'(wx_reg);
        coef_next[0][0] = eww + exx - eyy - ezz;
        coef_next[0][1] = (exy - ewz) <<< 1;
        coef_next[0][2] = (exz + ewy) <<< 1;
        coef_next[1][0] = (exy + ewz) <<< 1;
        coef_next[1][1] = eww - exx + eyy - ezz;
        coef_next[1][2] = (eyz - ewx) <<< 1;
        coef_next[2][0] = (exz - ewy) <<< 1;
        coef_next[2][1] = (eyz + ewx) <<< 1;
        coef_next[2][2] = eww - exx - eyy + ezz;
    end

    assign row_adv.mul = adv[2];
    assign row_adv.sum = adv[3];

    qvr_row u_row_x (
        .clk   (clk),
        .adv   (row_adv),
        .coef  (coef_reg[0]),
        .point (pt2_reg),
        .acc   (row_acc[0])
    );

    qvr_row u_row_y (
        .clk   (clk),
        .adv   (row_adv),
        .coef  (coef_reg[1]),
        .point (pt2_reg),
        .acc   (row_acc[1])
    );

    qvr_row u_row_z (
        .clk   (clk),
        .adv   (row_adv),
        .coef  (coef_reg[2]),
        .point (pt2_reg),
        .acc   (row_acc[2])
    );

    // drop fraction bits (rounding bias already added), then saturate
    always_comb
    begin
        logic signed [qvr_pkg::ACC_BITS-1:0]   shifted;
        logic signed [SB-1:0]                  scaled;
        logic signed [qvr_pkg::COORD_BITS-1:0] coord [3];
        logic                                  clip;
        clip = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            shifted = row_acc[r] >>> qvr_pkg::FRAC_BITS;
            scaled  = shifted[SB-1:0];
            if (scaled > SB'(qvr_pkg::COORD_MAX))
            begin
                coord[r] = qvr_pkg::COORD_MAX;
                clip     = 1'b1;
            end
            else if (scaled < SB'(qvr_pkg::COORD_MIN))
            begin
                coord[r] = qvr_pkg::COORD_MIN;
                clip     = 1'b1;
            end
            else
            begin
                coord[r] = scaled[qvr_pkg::COORD_BITS-1:0];
            end
        end
        result_next.rotated_x = coord[0];
        result_next.rotated_y = coord[1];
        result_next.rotated_z = coord[2];
        result_next.clipped   = clip;
    end

    assign result_valid = vld_reg[4];
    assign result       = result_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> ((&vld_reg) && result_stall))
        else $error("input stalled while pipeline has a free stage");

    a_accept_enters_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point_stall) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.clipped) |->
            (result.rotated_x == qvr_pkg::COORD_MAX || result.rotated_x == qvr_pkg::COORD_MIN ||
             result.rotated_y == qvr_pkg::COORD_MAX || result.rotated_y == qvr_pkg::COORD_MIN ||
             result.rotated_z == qvr_pkg::COORD_MAX || result.rotated_z == qvr_pkg::COORD_MIN))
        else $error("clipped flag without a saturated coordinate");

endmodule
